FILE: design/pcp_pkg.sv
// Package for the packed component pool: sizes, request and status codes,
// and the result record. No dependencies.
package pcp_pkg;
    localparam int POOL_DEPTH   = 64;
    localparam int ENTITY_LIMIT = 1024;
    localparam int WORD_BITS    = 64;
    localparam int SLOT_W       = $clog2(POOL_DEPTH);
    localparam int COUNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int ENT_W        = 10;
    localparam int MAP_W        = SLOT_W + 1;

    typedef enum logic [2:0] {
        REQ_INSERT = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_READ   = 3'd2,
        REQ_WRITE  = 3'd3,
        REQ_SCAN   = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_FULL    = 2'd2,
        ST_PRESENT = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [9:0]  entity_id;
        logic [63:0] component_word;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  out_entity;
        logic [5:0]  slot_index;
        logic [63:0] out_word;
        logic [6:0]  entry_count;
        logic        last_result;
    } rsp_item_t;
endpackage

FILE: design/pcp_req_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on pcp_pkg.
interface pcp_req_if;
    logic                valid;
    logic                ready;
    pcp_pkg::req_item_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pcp_rsp_if;
    logic                valid;
    logic                ready;
    pcp_pkg::rsp_item_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: design/pcp_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module pcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/pcp_map_clear.sv
// Clearing sweep for the entity-to-slot map after reset.
// Depends on pcp_pkg.
module pcp_map_clear (
    input  logic                                    clk,
    input  logic                                    rst_n,
    output logic                                    busy,
    output logic [$clog2(pcp_pkg::ENTITY_LIMIT)-1:0] addr
);
    localparam int AW = $clog2(pcp_pkg::ENTITY_LIMIT);
    logic [AW-1:0] addr_reg;
    logic          busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            addr_reg <= addr_reg + 1'b1;
            if (addr_reg == AW'(pcp_pkg::ENTITY_LIMIT - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign addr = addr_reg;
endmodule

FILE: design/packed_component_pool_core.sv
// Top level of the packed component pool: request sequencer around three RAMs.
// Depends on pcp_pkg, pcp_req_if, pcp_rsp_if, pcp_ram and pcp_map_clear.
// After reset the entity map is cleared, one entry a cycle, all 1024 entries; no request is taken.
// Results are set in S_OUT after the map lookup; read passes S_RM_LAST first, remove S_RM_LAST and
// S_RM_FIX. No request is taken before the result is set; scan loops S_SCAN_RD, S_SCAN_OUT per entry.
// A waiting result stalls the next request after its transfer, before the map lookup.
module packed_component_pool_core (
    input  logic      clk,
    input  logic      rst_n,
    pcp_req_if.sink   req,
    pcp_rsp_if.source rsp
);
    localparam int SW = pcp_pkg::SLOT_W;
    localparam int CW = pcp_pkg::COUNT_W;
    localparam int MW = pcp_pkg::MAP_W;
    localparam int EA = $clog2(pcp_pkg::ENTITY_LIMIT);
    localparam int WB = pcp_pkg::WORD_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_MAP, S_DECIDE, S_RM_LAST, S_RM_FIX, S_SCAN_RD, S_SCAN_OUT, S_OUT
    } state_t;

    state_t          state_reg;
    pcp_pkg::req_item_t rq_reg;
    logic [CW-1:0]   count_reg;
    logic [SW-1:0]   slot_reg;
    logic [SW-1:0]   scan_reg;
    logic [63:0]     old_reg;
    logic            rsp_valid_reg;
    pcp_pkg::rsp_item_t rsp_reg;

    logic            clr_busy;
    logic [EA-1:0]   clr_addr;

    logic            map_we;
    logic [EA-1:0]   map_waddr, map_raddr;
    logic [MW-1:0]   map_wdata, map_rdata;
    logic            own_we;
    logic [SW-1:0]   own_waddr, own_raddr;
    logic [9:0]      own_wdata, own_rdata;
    logic            dat_we;
    logic [SW-1:0]   dat_waddr, dat_raddr;
    logic [WB-1:0]   dat_wdata, dat_rdata;

    logic            inrange, present;
    logic [SW-1:0]   map_slot;
    logic [WB-1:0]   in_word;
    logic [SW-1:0]   last_slot;
    logic            rq_accept;

    pcp_map_clear u_clear (.clk(clk), .rst_n(rst_n), .busy(clr_busy), .addr(clr_addr));

    pcp_ram #(.WIDTH(MW), .DEPTH(pcp_pkg::ENTITY_LIMIT)) u_map (
        .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata));
    pcp_ram #(.WIDTH(10), .DEPTH(pcp_pkg::POOL_DEPTH)) u_owner (
        .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
        .raddr(own_raddr), .rdata(own_rdata));
    pcp_ram #(.WIDTH(WB), .DEPTH(pcp_pkg::POOL_DEPTH)) u_data (
        .clk(clk), .we(dat_we), .waddr(dat_waddr), .wdata(dat_wdata),
        .raddr(dat_raddr), .rdata(dat_rdata));

    assign req.ready = (state_reg == S_IDLE) && !clr_busy;
    assign rq_accept = req.valid && req.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    assign inrange  = 32'(rq_reg.entity_id) < pcp_pkg::ENTITY_LIMIT;
    assign present  = inrange && map_rdata[MW-1];
    assign map_slot = map_rdata[SW-1:0];
    assign in_word  = rq_reg.component_word[WB-1:0];
    assign last_slot = SW'(count_reg - 1'b1);

    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = rq_reg.entity_id[EA-1:0];
        map_wdata = '0;
        map_raddr = rq_reg.entity_id[EA-1:0];
        own_we    = 1'b0;
        own_waddr = slot_reg;
        own_wdata = own_rdata;
        own_raddr = last_slot;
        dat_we    = 1'b0;
        dat_waddr = slot_reg;
        dat_wdata = in_word;
        dat_raddr = map_slot;
        if (clr_busy)
        begin
            map_we    = 1'b1;
            map_waddr = clr_addr;
        end
        unique case (state_reg) inside
            S_DECIDE:
            begin
                if (rq_reg.req_type == pcp_pkg::REQ_INSERT && inrange && !present
                    && 32'(count_reg) < pcp_pkg::POOL_DEPTH)
                begin
                    map_we    = 1'b1;
                    map_wdata = {1'b1, SW'(count_reg)};
                    own_we    = 1'b1;
                    own_waddr = SW'(count_reg);
                    own_wdata = rq_reg.entity_id;
                    dat_we    = 1'b1;
                    dat_waddr = SW'(count_reg);
                end
                else if (rq_reg.req_type == pcp_pkg::REQ_WRITE && present)
                begin
                    dat_we    = 1'b1;
                    dat_waddr = map_slot;
                end
                else if (rq_reg.req_type == pcp_pkg::REQ_REMOVE && present)
                begin
                    map_we = 1'b1;
                end
            end
            S_RM_LAST:
            begin
                dat_raddr = last_slot;
            end
            S_RM_FIX:
            begin
                own_we    = 1'b1;
                dat_we    = 1'b1;
                dat_wdata = dat_rdata;
                if (32'(own_rdata) < pcp_pkg::ENTITY_LIMIT && !clr_busy
                    && own_rdata != rq_reg.entity_id)
                begin
                    map_we    = 1'b1;
                    map_waddr = own_rdata[EA-1:0];
                    map_wdata = {1'b1, slot_reg};
                end
            end
            S_SCAN_RD, S_SCAN_OUT:
            begin
                own_raddr = scan_reg;
                dat_raddr = scan_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            scan_reg      <= '0;
            rq_reg        <= '0;
            slot_reg      <= '0;
            old_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (rq_accept)
                    begin
                        rq_reg    <= req.payload;
                        state_reg <= S_MAP;
                    end
                end
                S_MAP:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    slot_reg <= map_slot;
                    rsp_reg  <= '{status: pcp_pkg::ST_ABSENT, out_entity: rq_reg.entity_id,
                                  slot_index: '0, out_word: '0, entry_count: count_reg,
                                  last_result: 1'b1};
                    state_reg <= S_OUT;
                    case (rq_reg.req_type)
                        pcp_pkg::REQ_INSERT:
                        begin
                            if (present)
                            begin
                                rsp_reg.status     <= pcp_pkg::ST_PRESENT;
                                rsp_reg.slot_index <= map_slot;
                            end
                            else if (inrange && 32'(count_reg) >= pcp_pkg::POOL_DEPTH)
                            begin
                                rsp_reg.status <= pcp_pkg::ST_FULL;
                            end
                            else if (inrange)
                            begin
                                rsp_reg.status      <= pcp_pkg::ST_OK;
                                rsp_reg.slot_index  <= SW'(count_reg);
                                rsp_reg.out_word    <= 64'(in_word);
                                rsp_reg.entry_count <= count_reg + 1'b1;
                                count_reg           <= count_reg + 1'b1;
                            end
                        end
                        pcp_pkg::REQ_WRITE:
                        begin
                            if (present)
                            begin
                                rsp_reg.status     <= pcp_pkg::ST_OK;
                                rsp_reg.slot_index <= map_slot;
                                rsp_reg.out_word   <= 64'(in_word);
                            end
                        end
                        pcp_pkg::REQ_READ:
                        begin
                            if (present)
                            begin
                                state_reg          <= S_RM_LAST;
                                rsp_reg.status     <= pcp_pkg::ST_OK;
                                rsp_reg.slot_index <= map_slot;
                            end
                        end
                        pcp_pkg::REQ_REMOVE:
                        begin
                            if (present && count_reg != '0)
                            begin
                                state_reg          <= S_RM_LAST;
                                rsp_reg.status     <= pcp_pkg::ST_OK;
                                rsp_reg.slot_index <= map_slot;
                            end
                        end
                        pcp_pkg::REQ_SCAN:
                        begin
                            rsp_reg.out_entity <= '0;
                            scan_reg           <= '0;
                            if (count_reg != '0)
                            begin
                                state_reg <= S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_RM_LAST:
                begin
                    // Data of the target slot arrives now; last slot is being read.
                    old_reg <= 64'(dat_rdata);
                    if (rq_reg.req_type == pcp_pkg::REQ_READ)
                    begin
                        rsp_reg.out_word <= 64'(dat_rdata);
                        state_reg        <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_RM_FIX;
                    end
                end
                S_RM_FIX:
                begin
                    rsp_reg.out_word    <= old_reg;
                    rsp_reg.entry_count <= count_reg - 1'b1;
                    count_reg           <= count_reg - 1'b1;
                    state_reg           <= S_OUT;
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_OUT;
                end
                S_SCAN_OUT:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_reg <= '{status: pcp_pkg::ST_OK, out_entity: own_rdata,
                                     slot_index: scan_reg, out_word: 64'(dat_rdata),
                                     entry_count: count_reg,
                                     last_result: (scan_reg == last_slot)};
                        if (scan_reg == last_slot)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            scan_reg  <= scan_reg + 1'b1;
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end
                S_OUT:
                begin
                    rsp_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= pcp_pkg::POOL_DEPTH)
        else $error("entry count beyond pool depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !req.ready)
        else $error("request taken during map clear");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RM_FIX) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("remove did not shrink pool");
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> $stable(rsp_reg))
        else $error("held result changed");
endmodule

FILE: tb/packed_component_pool_core_tb.sv
// Self-checking testbench for packed_component_pool_core: drives requests, predicts results
// with a behavioral sparse-set pool and checks every result transfer field by field.
// Depends on pcp_pkg, pcp_req_if, pcp_rsp_if and the design files.
module packed_component_pool_core_tb;
    localparam int EW = pcp_pkg::ENT_W;
    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    pcp_req_if req_ch ();
    pcp_rsp_if rsp_ch ();

    packed_component_pool_core uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch.sink),
        .rsp  (rsp_ch.source)
    );

    logic [pcp_pkg::MAP_W-1:0] pool_slot_of [pcp_pkg::ENTITY_LIMIT];
    logic [EW-1:0]             pool_owner [pcp_pkg::POOL_DEPTH];
    logic [63:0]               pool_word [pcp_pkg::POOL_DEPTH];
    int                        pool_count;
    pcp_pkg::rsp_item_t        pending_results [$];
    int                        errors;
    int                        idle_cycles;
    logic [EW-1:0]             live_ents [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic void add_expected(pcp_pkg::status_t st, logic [EW-1:0] ent,
                                         logic [5:0] slot, logic [63:0] word, bit last);
        pcp_pkg::rsp_item_t r;
        r.status      = st;
        r.out_entity  = ent;
        r.slot_index  = slot;
        r.out_word    = word;
        r.entry_count = pool_count[6:0];
        r.last_result = last;
        pending_results.insert(pending_results.size(), r);
    endfunction

    task automatic predict_pool(pcp_pkg::req_item_t it);
        bit              present;
        logic [5:0]      slot;
        logic [5:0]      tail;
        logic [EW-1:0]   mover;
        logic [63:0]     old;
        int              idx;
        present = pool_slot_of[it.entity_id][pcp_pkg::SLOT_W];
        slot = present ? pool_slot_of[it.entity_id][pcp_pkg::SLOT_W-1:0] : '0;
        idx = 0;
        case (it.req_type)
            pcp_pkg::REQ_INSERT:
                if (present)
                    add_expected(pcp_pkg::ST_PRESENT, it.entity_id, slot, '0, 1'b1);
                else if (pool_count >= pcp_pkg::POOL_DEPTH)
                    add_expected(pcp_pkg::ST_FULL, it.entity_id, '0, '0, 1'b1);
                else
                begin
                    slot = pool_count[5:0];
                    pool_word[slot] = it.component_word;
                    pool_owner[slot] = it.entity_id;
                    pool_slot_of[it.entity_id] = {1'b1, slot};
                    pool_count++;
                    live_ents.insert(live_ents.size(), it.entity_id);
                    add_expected(pcp_pkg::ST_OK, it.entity_id, slot, it.component_word, 1'b1);
                end
            pcp_pkg::REQ_REMOVE:
                if (!present)
                    add_expected(pcp_pkg::ST_ABSENT, it.entity_id, '0, '0, 1'b1);
                else
                begin
                    tail = 6'(pool_count - 1);
                    old = pool_word[slot];
                    mover = pool_owner[tail];
                    pool_word[slot] = pool_word[tail];
                    pool_owner[slot] = mover;
                    pool_slot_of[mover] = {1'b1, slot};
                    pool_slot_of[it.entity_id] = '0;
                    pool_count--;
                    foreach (live_ents[k])
                        if (live_ents[k] == it.entity_id)
                            idx = k;
                    live_ents.delete(idx);
                    add_expected(pcp_pkg::ST_OK, it.entity_id, slot, old, 1'b1);
                end
            pcp_pkg::REQ_READ:
                if (!present)
                    add_expected(pcp_pkg::ST_ABSENT, it.entity_id, '0, '0, 1'b1);
                else
                    add_expected(pcp_pkg::ST_OK, it.entity_id, slot, pool_word[slot], 1'b1);
            pcp_pkg::REQ_WRITE:
                if (!present)
                    add_expected(pcp_pkg::ST_ABSENT, it.entity_id, '0, '0, 1'b1);
                else
                begin
                    pool_word[slot] = it.component_word;
                    add_expected(pcp_pkg::ST_OK, it.entity_id, slot, it.component_word, 1'b1);
                end
            pcp_pkg::REQ_SCAN:
                if (pool_count == 0)
                    add_expected(pcp_pkg::ST_ABSENT, '0, '0, '0, 1'b1);
                else
                    for (int i = 0; i < pool_count; i++)
                        add_expected(pcp_pkg::ST_OK, pool_owner[i], i[5:0], pool_word[i],
                                     (i + 1) == pool_count);
            default:
                add_expected(pcp_pkg::ST_ABSENT, it.entity_id, '0, '0, 1'b1);
        endcase
    endtask

    task automatic send_request(logic [2:0] kind, logic [EW-1:0] ent, logic [63:0] word);
        pcp_pkg::req_item_t it;
        int                 gap;
        it.req_type = kind;
        it.entity_id = ent;
        it.component_word = word;
        gap = gap_len();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= it;
        @(posedge clk iff req_ch.ready);
        predict_pool(it);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [EW-1:0] pick_entity();
        if (live_ents.size() > 0 && $urandom_range(0, 3) != 0)
            return live_ents[$urandom_range(0, live_ents.size() - 1)];
        return EW'($urandom_range(0, pcp_pkg::ENTITY_LIMIT - 1));
    endfunction

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() > 0) @(posedge clk);
    endtask

    task automatic test_empty_pool();
        send_request(pcp_pkg::REQ_SCAN, 10'h155, '0);
        send_request(pcp_pkg::REQ_READ, '0, '0);
        send_request(pcp_pkg::REQ_REMOVE, 10'h3ff, '0);
        send_request(pcp_pkg::REQ_WRITE, 10'h2aa, '1);
        send_request(3'd5, 10'h3ff, '1);
        send_request(3'd7, '0, '0);
    endtask

    task automatic test_basic_ops();
        send_request(pcp_pkg::REQ_INSERT, '0, '1);
        send_request(pcp_pkg::REQ_INSERT, 10'h3ff, '0);
        send_request(pcp_pkg::REQ_INSERT, 10'h155, 64'haaaa_5555_aaaa_5555);
        send_request(pcp_pkg::REQ_INSERT, '0, 64'h1234);
        send_request(pcp_pkg::REQ_READ, 10'h3ff, '0);
        send_request(pcp_pkg::REQ_WRITE, 10'h3ff, 64'h5555_aaaa_5555_aaaa);
        send_request(pcp_pkg::REQ_SCAN, '0, '0);
        send_request(pcp_pkg::REQ_REMOVE, '0, '0);
        send_request(pcp_pkg::REQ_SCAN, '0, '0);
        send_request(pcp_pkg::REQ_REMOVE, 10'h155, '0);
        send_request(pcp_pkg::REQ_REMOVE, 10'h155, '0);
        send_request(3'd6, 10'h2aa, '0);
    endtask

    task automatic test_full_pool();
        logic [EW-1:0] e;
        while (pool_count < pcp_pkg::POOL_DEPTH)
        begin
            e = EW'($urandom_range(0, pcp_pkg::ENTITY_LIMIT - 1));
            if (!pool_slot_of[e][pcp_pkg::SLOT_W])
                send_request(pcp_pkg::REQ_INSERT, e, rand_word());
        end
        send_request(pcp_pkg::REQ_INSERT, live_ents[0], '0);
        do
            e = EW'($urandom_range(0, pcp_pkg::ENTITY_LIMIT - 1));
        while (pool_slot_of[e][pcp_pkg::SLOT_W]);
        send_request(pcp_pkg::REQ_INSERT, e, '1);
        send_request(pcp_pkg::REQ_SCAN, '0, '0);
        drain_results();
        while (pool_count > 0)
            send_request(pcp_pkg::REQ_REMOVE,
                         live_ents[$urandom_range(0, live_ents.size() - 1)], '0);
        send_request(pcp_pkg::REQ_SCAN, '0, '0);
    endtask

    task automatic test_random_mix(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                send_request(pcp_pkg::REQ_INSERT, pick_entity(), rand_word());
            else if (r < 55)
                send_request(pcp_pkg::REQ_REMOVE, pick_entity(), rand_word());
            else if (r < 72)
                send_request(pcp_pkg::REQ_READ, pick_entity(), rand_word());
            else if (r < 90)
                send_request(pcp_pkg::REQ_WRITE, pick_entity(), rand_word());
            else if (r < 96)
                send_request(pcp_pkg::REQ_SCAN,
                             EW'($urandom_range(0, pcp_pkg::ENTITY_LIMIT - 1)), rand_word());
            else
                send_request(3'($urandom_range(5, 7)), pick_entity(), rand_word());
            if (i == n / 2)
                drain_results();
        end
    endtask

    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            stall = gap_len();
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: %p", rsp_ch.payload);
                errors++;
            end
            else
            begin
                pcp_pkg::rsp_item_t exp;
                pcp_pkg::rsp_item_t got;
                exp = pending_results.pop_front();
                got = rsp_ch.payload;
                if (got.status !== exp.status)
                begin
                    $error("status: expected %0d, actual %0d", exp.status, got.status);
                    errors++;
                end
                if (got.out_entity !== exp.out_entity)
                begin
                    $error("out_entity: expected %0d, actual %0d", exp.out_entity, got.out_entity);
                    errors++;
                end
                if (got.slot_index !== exp.slot_index)
                begin
                    $error("slot_index: expected %0d, actual %0d", exp.slot_index, got.slot_index);
                    errors++;
                end
                if (got.out_word !== exp.out_word)
                begin
                    $error("out_word: expected %h, actual %h", exp.out_word, got.out_word);
                    errors++;
                end
                if (got.entry_count !== exp.entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d", exp.entry_count,
                           got.entry_count);
                    errors++;
                end
                if (got.last_result !== exp.last_result)
                begin
                    $error("last_result: expected %0d, actual %0d", exp.last_result,
                           got.last_result);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        pool_count = 0;
        foreach (pool_slot_of[k])
            pool_slot_of[k] = '0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_pool();
        test_basic_ops();
        test_full_pool();
        test_random_mix(16);
        drain_results();
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
